// ----- hw/rtl/msre_pkg.sv -----
// Package for the mask run span extractor.
// Holds the row geometry constants, the span record type and the span builder.
// Standalone; imported by mask_run_span_extractor.
package msre_pkg;

  localparam int LINE_PIXELS = 256;
  localparam int POS_W       = $clog2(LINE_PIXELS + 1);
  localparam int MASK_W      = 8;
  localparam int MAX_SPANS   = 5;
  localparam int CNT_W       = $clog2(MAX_SPANS + 1);
  localparam int SLOT_W      = $clog2(MAX_SPANS);

  localparam int COORD_W     = 12;
  localparam int OFFSET_W    = 8;
  localparam int LENGTH_W    = 9;
  localparam int SX_W        = 13;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 48;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [LENGTH_W-1:0] length;
    logic [SX_W-1:0]     sx;
  } span_t;

  // Build one span closed at end_pos, opened at start_pos.
  function automatic span_t make_span(input logic [POS_W-1:0]   end_pos,
                                      input logic [POS_W-1:0]   start_pos,
                                      input logic [COORD_W-1:0] ox);
    span_t s;
    s.offset = OFFSET_W'(start_pos);
    s.length = LENGTH_W'(end_pos - start_pos);
    s.sx     = {ox[COORD_W-1], ox} + SX_W'(start_pos);
    return s;
  endfunction

endpackage

// ----- hw/rtl/mask_run_span_extractor.sv -----
// Mask run span extractor top level.
// Scans one mask byte per transaction and queues the spans it closes.
// Depends on msre_pkg.
//
// Usage:
//   Input channel (in_*): one mask byte per transaction, msb = leftmost pixel,
//   with the row's screen origin and y. in_tlast marks the row's final byte and
//   flushes an open run; the pixel position then restarts at zero.
//   Output channel (out_*): one span per transaction. out_tlast is set on the
//   last span that a given mask byte produced. A byte that closes no run
//   produces no output transaction.
//   Timing: a span is registered and appears on out_* in the cycle after its byte is taken.
//   Throughput: one byte per cycle while each byte yields at most one span and out_tready stays high.
//   A byte yielding n spans (up to 5) holds the output until all n are accepted; the next
//   byte is taken in the cycle its last span is accepted. The span queue
//   drains through a single output register, which sets this rate.
//   Stall: while out_tready is low, queued spans hold and in_tready drops
//   once the queue holds more than what the current cycle can retire.
//   Reset (rst_n low, synchronous): empties the span queue, clears the pixel
//   position and any open run.
module mask_run_span_extractor
  import msre_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] mask_byte, [19:8] origin_x, [31:20] row_y
  input  logic                  in_tlast,   // last_byte

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] span_offset, [16:8] span_length,
                                            // [29:17] screen_x, [41:30] screen_y, zero pad
  output logic                  out_tlast   // final_of_item
);

  logic [MASK_W-1:0]  in_mask;
  logic [COORD_W-1:0] in_ox;
  logic [COORD_W-1:0] in_y;

  logic [POS_W-1:0]   pos_r,   pos_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;
  logic               open_r,  open_nxt;

  span_t              spans_r [MAX_SPANS];
  span_t              spans_nxt [MAX_SPANS];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [COORD_W-1:0] y_r;

  logic               in_fire;
  logic               out_fire;

  assign in_mask = in_tdata[MASK_W-1:0];
  assign in_ox   = in_tdata[MASK_W +: COORD_W];
  assign in_y    = in_tdata[MASK_W+COORD_W +: COORD_W];

  assign out_tvalid = (cnt_r != '0);
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_tready);
  assign in_fire    = in_tvalid && in_tready;

  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign out_tdata  = OUT_DATA_W'({y_r, spans_r[0].sx, spans_r[0].length, spans_r[0].offset});

  // Scan the byte msb first; close an open run on each clear bit or at the line end.
  always_comb begin
    logic set_v;
    logic sat_v;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    open_nxt  = open_r;
    cnt_nxt   = '0;
    for (int k = 0; k < MAX_SPANS; k++) begin
      spans_nxt[k] = '0;
    end
    for (int i = 0; i < MASK_W; i++) begin
      sat_v = (pos_nxt >= POS_W'(LINE_PIXELS));
      set_v = in_mask[MASK_W-1-i] && !sat_v;
      if (set_v) begin
        if (!open_nxt) begin
          open_nxt  = 1'b1;
          start_nxt = pos_nxt;
        end
      end else if (open_nxt) begin
        spans_nxt[SLOT_W'(cnt_nxt)] = make_span(pos_nxt, start_nxt, in_ox);
        cnt_nxt  = cnt_nxt + CNT_W'(1);
        open_nxt = 1'b0;
      end
      if (!sat_v) begin
        pos_nxt = pos_nxt + POS_W'(1);
      end
    end
    // Flush the open run at row end and restart the row.
    if (in_tlast) begin
      if (open_nxt) begin
        spans_nxt[SLOT_W'(cnt_nxt)] = make_span(pos_nxt, start_nxt, in_ox);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
      pos_nxt   = '0;
      start_nxt = '0;
      open_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      open_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      open_r  <= open_nxt;
      cnt_r   <= cnt_nxt;
    end else if (out_fire) begin
      cnt_r   <= cnt_r - CNT_W'(1);
    end
  end

  // Load a new batch of spans, or advance the queue by one on each pop.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      y_r <= in_y;
      for (int k = 0; k < MAX_SPANS; k++) begin
        spans_r[k] <= spans_nxt[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < MAX_SPANS - 1; k++) begin
        spans_r[k] <= spans_r[k+1];
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SPANS))
    else $error("span queue count above capacity");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LINE_PIXELS))
    else $error("pixel position beyond line length");

  a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (pos_r == '0) && !open_r)
    else $error("row state not cleared after last byte");

  a_open_start: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (start_r < pos_r))
    else $error("open run starts at or after current position");

  a_queue_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_fire))
    else $error("new byte taken while spans still queued");

endmodule
